@@ rtl/lgs_pkg.sv @@
// Package for the life generation step block.
// Holds the transaction payload types, operation codes and rule constants.
// No dependencies.
`default_nettype none

package lgs_pkg;

  // Operation codes carried in the input transaction
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // Neighbour counts of the birth / survival rule
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

  // Width used to range-check the cell coordinates (holds 256)
  localparam int IDX_W = 9;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] row;
    logic [5:0] col;
    logic       cell_in;
  } in_item_t;

  typedef struct packed {
    logic cell_out;
    logic generation_done;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/life_generation_step.sv @@
// Life generation step: one-bit cell grid with birth on 3, survival on 2 or 3.
// Holds the row memory, the window registers and the sequencer.
// Depends on lgs_pkg.
//
// Usage
//   Input channel (in_valid / in_stall / in_data) carries one transaction:
//   write a cell, read a cell or advance the grid by one generation.
//   Output channel (out_valid / out_stall / out_data) returns one result for
//   a read (cell value) or an advance (generation_done set); a write gives
//   none. Coordinates outside the grid: a write is dropped, a read returns 0.
//   The grid is a memory of ROWS words of COLS bits, one row per word.
//   The advance sweeps rows 1 to ROWS-1 and columns 1 to COLS-1 one cell per
//   cycle within a row through a single neighbour-count unit; row 0 and
//   column 0 keep their values. Each row of the memory is read once and
//   each swept row is written once.
//   One transaction is in work at a time; in_stall is high while busy.
//   Reset clears the per-row valid bits, so every cell reads as dead; no
//   clearing pass is needed. A result that the receiver stalls is held in
//   the output register; the block then waits before taking more work only
//   if a further result is ready to be loaded.
`default_nettype none

module life_generation_step
  import lgs_pkg::*;
#(
  parameter int ROWS = 32,
  parameter int COLS = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_WR_MOD = 4'd1;
  localparam logic [3:0] S_RD_SEL = 4'd2;
  localparam logic [3:0] S_RESP   = 4'd3;
  localparam logic [3:0] S_G_RD0  = 4'd4;
  localparam logic [3:0] S_G_RD1  = 4'd5;
  localparam logic [3:0] S_G_RD2  = 4'd6;
  localparam logic [3:0] S_G_LD   = 4'd7;
  localparam logic [3:0] S_G_CELL = 4'd8;
  localparam logic [3:0] S_G_WR   = 4'd9;

  // Row memory and per-row valid bits
  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_vld_r;
  logic [COLS-1:0] rd_data_r;
  logic            rd_vld_r;

  logic            rd_en;
  logic [RW-1:0]   rd_addr;
  logic            wr_en;
  logic [RW-1:0]   wr_addr;
  logic [COLS-1:0] wr_data;
  logic [COLS-1:0] rd_row;

  // Sequencer and datapath registers
  logic [3:0]      state_r, state_nxt;
  logic [RW-1:0]   op_row_r, op_row_nxt;
  logic [CW-1:0]   op_col_r, op_col_nxt;
  logic            op_val_r, op_val_nxt;
  logic            resp_cell_r, resp_cell_nxt;
  logic            resp_gen_r, resp_gen_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic [RW-1:0]   gen_row_r, gen_row_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic            nxt_pend_r, nxt_pend_nxt;
  logic [COLS-1:0] prev_r, prev_nxt;
  logic [COLS-1:0] cur_r, cur_nxt;
  logic [COLS-1:0] next_r, next_nxt;
  logic [COLS-1:0] new_row_r, new_row_nxt;

  // Input decode
  logic [IDX_W-1:0] in_row_ext, in_col_ext;
  logic             in_inside;
  logic             in_acc;

  // Neighbour-count unit
  logic [CW:0]     col_lo, col_mid, col_hi;
  logic [3:0]      nb_count;
  logic            cell_new;

  function automatic logic bit_at(input logic [COLS-1:0] v, input logic [CW:0] i);
    logic res;
    res = 1'b0;
    if (i < (CW+1)'(COLS)) begin
      res = v[i[CW-1:0]];
    end
    return res;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_row_ext = IDX_W'(in_data.row);
  assign in_col_ext = IDX_W'(in_data.col);
  assign in_inside  = (in_row_ext < IDX_W'(ROWS)) && (in_col_ext < IDX_W'(COLS));

  // Rows never written since reset read as dead
  assign rd_row = rd_vld_r ? rd_data_r : '0;

  // Count the eight neighbours of the current column and apply the rule
  assign col_mid = {1'b0, col_r};
  assign col_lo  = col_mid - (CW+1)'(1);
  assign col_hi  = col_mid + (CW+1)'(1);

  always_comb begin
    nb_count = 4'(bit_at(prev_r, col_lo)) + 4'(bit_at(prev_r, col_mid))
             + 4'(bit_at(prev_r, col_hi)) + 4'(bit_at(cur_r, col_lo))
             + 4'(bit_at(cur_r, col_hi))  + 4'(bit_at(next_r, col_lo))
             + 4'(bit_at(next_r, col_mid)) + 4'(bit_at(next_r, col_hi));
    cell_new = (nb_count == BIRTH_COUNT) ||
               ((nb_count == KEEP_COUNT) && bit_at(cur_r, col_mid));
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    op_row_nxt    = op_row_r;
    op_col_nxt    = op_col_r;
    op_val_nxt    = op_val_r;
    resp_cell_nxt = resp_cell_r;
    resp_gen_nxt  = resp_gen_r;
    gen_row_nxt   = gen_row_r;
    col_nxt       = col_r;
    nxt_pend_nxt  = nxt_pend_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    next_nxt      = next_r;
    new_row_nxt   = new_row_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = op_row_r;
    wr_data       = rd_row;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_row_nxt = in_row_ext[RW-1:0];
          op_col_nxt = in_col_ext[CW-1:0];
          op_val_nxt = in_data.cell_in;
          case (in_data.operation)
            OP_WRITE: begin
              if (in_inside) begin
                rd_en     = 1'b1;
                rd_addr   = in_row_ext[RW-1:0];
                state_nxt = S_WR_MOD;
              end
            end
            OP_ADVANCE: begin
              state_nxt = S_G_RD0;
            end
            OP_READ: begin
              resp_cell_nxt = 1'b0;
              resp_gen_nxt  = 1'b0;
              if (in_inside) begin
                rd_en     = 1'b1;
                rd_addr   = in_row_ext[RW-1:0];
                state_nxt = S_RD_SEL;
              end else begin
                state_nxt = S_RESP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_WR_MOD: begin
        // Modify one bit of the row and write it back
        wr_en             = 1'b1;
        wr_addr           = op_row_r;
        wr_data           = rd_row;
        wr_data[op_col_r] = op_val_r;
        state_nxt         = S_IDLE;
      end
      S_RD_SEL: begin
        resp_cell_nxt = rd_row[op_col_r];
        resp_gen_nxt  = 1'b0;
        state_nxt     = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.cell_out        = resp_cell_r;
          out_data_nxt.generation_done = resp_gen_r;
          state_nxt                    = S_IDLE;
        end
      end
      S_G_RD0: begin
        rd_en       = 1'b1;
        rd_addr     = '0;
        gen_row_nxt = RW'(1);
        state_nxt   = S_G_RD1;
      end
      S_G_RD1: begin
        prev_nxt  = rd_row;
        rd_en     = 1'b1;
        rd_addr   = RW'(1);
        state_nxt = S_G_RD2;
      end
      S_G_RD2: begin
        cur_nxt      = rd_row;
        rd_en        = 1'b1;
        rd_addr      = RW'(2);
        nxt_pend_nxt = 1'b1;
        state_nxt    = S_G_LD;
      end
      S_G_LD: begin
        // Load the row below; below the last row everything is dead
        next_nxt    = nxt_pend_r ? rd_row : '0;
        new_row_nxt = cur_r;
        col_nxt     = CW'(1);
        state_nxt   = S_G_CELL;
      end
      S_G_CELL: begin
        new_row_nxt[col_r] = cell_new;
        if (col_r == CW'(COLS - 1)) begin
          state_nxt = S_G_WR;
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
      S_G_WR: begin
        // Store the new row, slide the window of old rows down by one
        wr_en    = 1'b1;
        wr_addr  = gen_row_r;
        wr_data  = new_row_r;
        prev_nxt = cur_r;
        cur_nxt  = next_r;
        if (gen_row_r == RW'(ROWS - 1)) begin
          resp_cell_nxt = 1'b0;
          resp_gen_nxt  = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          gen_row_nxt = gen_row_r + RW'(1);
          if (({1'b0, gen_row_r} + (RW+1)'(2)) < (RW+1)'(ROWS)) begin
            rd_en        = 1'b1;
            rd_addr      = gen_row_r + RW'(2);
            nxt_pend_nxt = 1'b1;
          end else begin
            nxt_pend_nxt = 1'b0;
          end
          state_nxt = S_G_LD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_row_r    <= op_row_nxt;
    op_col_r    <= op_col_nxt;
    op_val_r    <= op_val_nxt;
    resp_cell_r <= resp_cell_nxt;
    resp_gen_r  <= resp_gen_nxt;
    out_data_r  <= out_data_nxt;
    gen_row_r   <= gen_row_nxt;
    col_r       <= col_nxt;
    nxt_pend_r  <= nxt_pend_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    next_r      <= next_nxt;
    new_row_r   <= new_row_nxt;
  end

  // Row memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= row_vld_r[rd_addr];
    end
  end

  // Assertions
  a_rd_wr_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("row memory read and written at the same row");

  a_col_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_G_CELL) |-> (col_r != '0))
    else $error("column zero entered the generation sweep");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.cell_out && out_data_r.generation_done))
    else $error("generation result carries a cell value");

  a_busy_after_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_data.operation == OP_ADVANCE)) |=> (state_r == S_G_RD0))
    else $error("advance transaction did not start the sweep");

endmodule

`default_nettype wire
